/* design/bir_pkg.sv */
`default_nettype none

package bir_pkg;

	// Frame geometry
	localparam int MAX_SRC_SIZE = 512;
	localparam int MAX_DST_SIZE = 1024;
	localparam int MAX_CHANNELS = 3;
	localparam int FRAC_BITS    = 16;

	// Field and register widths
	localparam int SRC_W     = $clog2(MAX_SRC_SIZE);          // source index
	localparam int SRC_CFG_W = $clog2(MAX_SRC_SIZE) + 1;      // src_size register
	localparam int CNT_W     = $clog2(MAX_DST_SIZE);          // output counters
	localparam int DST_CFG_W = $clog2(MAX_DST_SIZE) + 1;      // dst_size register
	localparam int CH_W      = 2;
	localparam int STEP_W    = 24;
	localparam int SAMPLE_W  = 8;
	localparam int CFG_W     = 24;

	// Frame store
	localparam int STORE_DEPTH = MAX_SRC_SIZE * MAX_SRC_SIZE * MAX_CHANNELS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	// Interpolation arithmetic
	localparam int POS_W = CNT_W + STEP_W;
	localparam int IP_W  = POS_W - FRAC_BITS;
	localparam int WGT_W = FRAC_BITS + 1;
	localparam int TOP_W = WGT_W + SAMPLE_W;
	localparam int PRD_W = WGT_W + TOP_W;
	localparam int SUM_W = 2 * FRAC_BITS + SAMPLE_W;

	localparam logic [WGT_W-1:0] WGT_ONE  = WGT_W'(1) << FRAC_BITS;
	localparam logic [SUM_W:0]   ROUND_HALF = (SUM_W + 1)'(1) << (2 * FRAC_BITS - 1);

	// Request kinds carried in tuser
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EMIT = 1'b1;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_SRC_SIZE   = 2'd0,
		CFG_DST_SIZE   = 2'd1,
		CFG_CHANNELS   = 2'd2,
		CFG_STEP_RATIO = 2'd3
	} bir_cfg_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOCATE,
		ST_SPLIT,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_MIX1,
		ST_MIX2,
		ST_MIX3
	} bir_state_t;

	// Frame store access
	typedef struct packed {
		logic                we;
		logic                re;
		logic [SRC_W-1:0]    row;
		logic [SRC_W-1:0]    col;
		logic [CH_W-1:0]     chan;
		logic [SAMPLE_W-1:0] wdata;
	} bir_mem_req_t;

endpackage

`default_nettype wire

/* design/bilinear_image_resizer.sv */
`default_nettype none

// Bilinear scaler for square raw images held in an on-chip frame store of
// 512 x 512 x 3 bytes. A load request (tuser = 0) writes one source sample;
// loads to channel 3 are dropped. An emit request (tuser = 1) produces the next
// output sample in row, column, channel order with tlast on the final sample of
// the frame, after which the counters wrap to zero. An emit runs from acceptance
// to the next ready through LOCATE and SPLIT, which locate the source position
// (counter times step_ratio, clamped to src_size-1), RD0 to RD3, which read the
// four neighbours one at a time from the single-port frame store, and MIX1 to
// MIX3, which weight, sum and round; MIX3 holds while an earlier result is untaken.
// The result sits in an output register, so the next request is taken while it waits.
// Write registers only while no request is in flight; samples that were never
// loaded read back as unknown values.
module bilinear_image_resizer (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_wen,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_wdata,

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// load_row[8:0], load_col[17:9], load_channel[19:18], sample[27:20], zero pad
	input  wire logic [31:0] s_axis_tdata,
	// func[0]
	input  wire logic [0:0]  s_axis_tuser,

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// value[7:0], out_row[17:8], out_col[27:18], out_channel[29:28], zero pad
	output logic [31:0]      m_axis_tdata,
	output logic             m_axis_tlast
);
	import bir_pkg::*;

	// Configuration registers
	logic [SRC_CFG_W-1:0] src_size_q;
	logic [DST_CFG_W-1:0] dst_size_q;
	logic [CH_W-1:0]      channels_q;
	logic [STEP_W-1:0]    step_q;

	// Saturated configuration
	logic [SRC_CFG_W-1:0] src_eff;
	logic [SRC_W-1:0]     src_last;
	logic [DST_CFG_W-1:0] dst_eff;
	logic [CH_W-1:0]      nch_eff;

	// Output counters
	logic [CNT_W-1:0]     row_cnt_q;
	logic [CNT_W-1:0]     col_cnt_q;
	logic [CH_W-1:0]      chan_cnt_q;
	logic [CH_W:0]        chan_inc;
	logic [CNT_W:0]       col_inc;
	logic [CNT_W:0]       row_inc;
	logic                 chan_wrap;
	logic                 col_wrap;
	logic                 row_wrap;

	// Request fields
	logic                 in_func;
	logic [SRC_W-1:0]     in_row;
	logic [SRC_W-1:0]     in_col;
	logic [CH_W-1:0]      in_chan;
	logic [SAMPLE_W-1:0]  in_sample;
	logic                 in_accept;

	// Work registers of one emit
	logic [CNT_W-1:0]     row_q;
	logic [CNT_W-1:0]     col_q;
	logic [CH_W-1:0]      chan_q;
	logic                 last_q;
	logic [POS_W-1:0]     pos_row_q;
	logic [POS_W-1:0]     pos_col_q;
	logic [SRC_W-1:0]     r0_q;
	logic [SRC_W-1:0]     r1_q;
	logic [SRC_W-1:0]     c0_q;
	logic [SRC_W-1:0]     c1_q;
	logic [FRAC_BITS-1:0] fr_q;
	logic [FRAC_BITS-1:0] fc_q;
	logic [SAMPLE_W-1:0]  s00_q;
	logic [SAMPLE_W-1:0]  s01_q;
	logic [SAMPLE_W-1:0]  s10_q;
	logic [TOP_W-1:0]     top_q;
	logic [TOP_W-1:0]     bot_q;
	logic [PRD_W-1:0]     prd_top_q;
	logic [PRD_W-1:0]     prd_bot_q;

	// Datapath intermediates
	logic [POS_W-1:0]     pos_row_d;
	logic [POS_W-1:0]     pos_col_d;
	logic [WGT_W-1:0]     wc0;
	logic [WGT_W-1:0]     wr0;
	logic [TOP_W-1:0]     top_d;
	logic [TOP_W-1:0]     bot_d;
	logic [PRD_W-1:0]     prd_top_d;
	logic [PRD_W-1:0]     prd_bot_d;
	logic [SUM_W:0]       sum_d;

	// Output register
	logic                 out_valid_q;
	logic [SAMPLE_W-1:0]  out_value_q;
	logic [CNT_W-1:0]     out_row_q;
	logic [CNT_W-1:0]     out_col_q;
	logic [CH_W-1:0]      out_chan_q;
	logic                 out_last_q;
	logic                 out_load;

	// Sequencer
	bir_state_t           state_q;
	bir_state_t           state_d;
	bir_mem_req_t         mem_req;
	logic [SAMPLE_W-1:0]  mem_rdata;

	// Clamp an integer source position to the last source index
	function automatic logic [SRC_W-1:0] clamp_idx(
		input logic [IP_W:0]    ip,
		input logic [SRC_W-1:0] last
	);
		clamp_idx = (ip > (IP_W + 1)'(last)) ? last : ip[SRC_W-1:0];
	endfunction

	// Unpack the request
	assign in_func   = s_axis_tuser[0];
	assign in_row    = s_axis_tdata[8:0];
	assign in_col    = s_axis_tdata[17:9];
	assign in_chan   = s_axis_tdata[19:18];
	assign in_sample = s_axis_tdata[27:20];
	assign in_accept = s_axis_tvalid && s_axis_tready;

	// Saturate the configuration into its legal range
	always_comb begin
		if (src_size_q == '0) begin
			src_eff = SRC_CFG_W'(1);
		end else if (src_size_q > SRC_CFG_W'(MAX_SRC_SIZE)) begin
			src_eff = SRC_CFG_W'(MAX_SRC_SIZE);
		end else begin
			src_eff = src_size_q;
		end
		if (dst_size_q == '0) begin
			dst_eff = DST_CFG_W'(1);
		end else if (dst_size_q > DST_CFG_W'(MAX_DST_SIZE)) begin
			dst_eff = DST_CFG_W'(MAX_DST_SIZE);
		end else begin
			dst_eff = dst_size_q;
		end
		if (channels_q == '0) begin
			nch_eff = CH_W'(1);
		end else if (channels_q > CH_W'(MAX_CHANNELS)) begin
			nch_eff = CH_W'(MAX_CHANNELS);
		end else begin
			nch_eff = channels_q;
		end
	end

	assign src_last = SRC_W'(src_eff - SRC_CFG_W'(1));

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_size_q <= SRC_CFG_W'(512);
			dst_size_q <= DST_CFG_W'(650);
			channels_q <= CH_W'(3);
			step_q     <= STEP_W'(51601);
		end else if (cfg_wen) begin
			unique case (bir_cfg_t'(cfg_index))
				CFG_SRC_SIZE:   src_size_q <= cfg_wdata[SRC_CFG_W-1:0];
				CFG_DST_SIZE:   dst_size_q <= cfg_wdata[DST_CFG_W-1:0];
				CFG_CHANNELS:   channels_q <= cfg_wdata[CH_W-1:0];
				CFG_STEP_RATIO: step_q     <= cfg_wdata[STEP_W-1:0];
				default:        ;
			endcase
		end
	end

	// Advance channel, then column, then row
	assign chan_inc  = (CH_W + 1)'(chan_cnt_q) + (CH_W + 1)'(1);
	assign col_inc   = (CNT_W + 1)'(col_cnt_q) + (CNT_W + 1)'(1);
	assign row_inc   = (CNT_W + 1)'(row_cnt_q) + (CNT_W + 1)'(1);
	assign chan_wrap = chan_inc >= (CH_W + 1)'(nch_eff);
	assign col_wrap  = col_inc >= dst_eff;
	assign row_wrap  = row_inc >= dst_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q  <= '0;
			col_cnt_q  <= '0;
			chan_cnt_q <= '0;
		end else if (in_accept && in_func == FUNC_EMIT) begin
			if (!chan_wrap) begin
				chan_cnt_q <= chan_inc[CH_W-1:0];
			end else begin
				chan_cnt_q <= '0;
				if (!col_wrap) begin
					col_cnt_q <= col_inc[CNT_W-1:0];
				end else begin
					col_cnt_q <= '0;
					row_cnt_q <= row_wrap ? '0 : row_inc[CNT_W-1:0];
				end
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept && in_func == FUNC_EMIT) begin
					state_d = ST_LOCATE;
				end
			end
			ST_LOCATE: state_d = ST_SPLIT;
			ST_SPLIT:  state_d = ST_RD0;
			ST_RD0:    state_d = ST_RD1;
			ST_RD1:    state_d = ST_RD2;
			ST_RD2:    state_d = ST_RD3;
			ST_RD3:    state_d = ST_MIX1;
			ST_MIX1:   state_d = ST_MIX2;
			ST_MIX2:   state_d = ST_MIX3;
			ST_MIX3: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer outputs: ready, frame store access, output load
	always_comb begin
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		mem_req       = '0;
		mem_req.chan  = chan_q;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				mem_req.we    = s_axis_tvalid && in_func == FUNC_LOAD
				                && in_chan < CH_W'(MAX_CHANNELS);
				mem_req.row   = in_row;
				mem_req.col   = in_col;
				mem_req.chan  = in_chan;
				mem_req.wdata = in_sample;
			end
			ST_RD0: begin
				mem_req.re  = 1'b1;
				mem_req.row = r0_q;
				mem_req.col = c0_q;
			end
			ST_RD1: begin
				mem_req.re  = 1'b1;
				mem_req.row = r0_q;
				mem_req.col = c1_q;
			end
			ST_RD2: begin
				mem_req.re  = 1'b1;
				mem_req.row = r1_q;
				mem_req.col = c0_q;
			end
			ST_RD3: begin
				mem_req.re  = 1'b1;
				mem_req.row = r1_q;
				mem_req.col = c1_q;
			end
			ST_MIX3: begin
				out_load = !out_valid_q || m_axis_tready;
			end
			default: ;
		endcase
	end

	bir_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	// Source positions and weights
	assign pos_row_d = POS_W'(row_q) * POS_W'(step_q);
	assign pos_col_d = POS_W'(col_q) * POS_W'(step_q);
	assign wc0       = WGT_ONE - WGT_W'(fc_q);
	assign wr0       = WGT_ONE - WGT_W'(fr_q);

	// Horizontal blend of both rows; the last neighbour arrives straight from the store
	assign top_d     = TOP_W'(wc0) * TOP_W'(s00_q) + TOP_W'(fc_q) * TOP_W'(s01_q);
	assign bot_d     = TOP_W'(wc0) * TOP_W'(s10_q) + TOP_W'(fc_q) * TOP_W'(mem_rdata);

	// Vertical blend and round half up
	assign prd_top_d = PRD_W'(wr0) * PRD_W'(top_q);
	assign prd_bot_d = PRD_W'(fr_q) * PRD_W'(bot_q);
	assign sum_d     = (SUM_W + 1)'(prd_top_q[SUM_W-1:0]) + (SUM_W + 1)'(prd_bot_q[SUM_W-1:0])
	                   + ROUND_HALF;

	// Work registers, loaded as the sequencer passes through each state
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_accept && in_func == FUNC_EMIT) begin
			row_q  <= row_cnt_q;
			col_q  <= col_cnt_q;
			chan_q <= chan_cnt_q;
			last_q <= chan_wrap && col_wrap && row_wrap;
		end
		if (state_q == ST_LOCATE) begin
			pos_row_q <= pos_row_d;
			pos_col_q <= pos_col_d;
		end
		if (state_q == ST_SPLIT) begin
			r0_q <= clamp_idx((IP_W + 1)'(pos_row_q[POS_W-1:FRAC_BITS]), src_last);
			r1_q <= clamp_idx((IP_W + 1)'(pos_row_q[POS_W-1:FRAC_BITS])
			                  + (IP_W + 1)'(|pos_row_q[FRAC_BITS-1:0]), src_last);
			c0_q <= clamp_idx((IP_W + 1)'(pos_col_q[POS_W-1:FRAC_BITS]), src_last);
			c1_q <= clamp_idx((IP_W + 1)'(pos_col_q[POS_W-1:FRAC_BITS])
			                  + (IP_W + 1)'(|pos_col_q[FRAC_BITS-1:0]), src_last);
			fr_q <= pos_row_q[FRAC_BITS-1:0];
			fc_q <= pos_col_q[FRAC_BITS-1:0];
		end
		if (state_q == ST_RD1) begin
			s00_q <= mem_rdata;
		end
		if (state_q == ST_RD2) begin
			s01_q <= mem_rdata;
		end
		if (state_q == ST_RD3) begin
			s10_q <= mem_rdata;
		end
		if (state_q == ST_MIX1) begin
			top_q <= top_d;
			bot_q <= bot_d;
		end
		if (state_q == ST_MIX2) begin
			prd_top_q <= prd_top_d;
			prd_bot_q <= prd_bot_d;
		end
	end

	// Output register: hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= sum_d[SUM_W-1:2*FRAC_BITS];
			out_row_q   <= row_q;
			out_col_q   <= col_q;
			out_chan_q  <= chan_q;
			out_last_q  <= last_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {2'b00, out_chan_q, out_col_q, out_row_q, out_value_q};

	// The channel counter never reaches the channel limit
	assert property (@(posedge clk) disable iff (!arst_n)
		chan_cnt_q < CH_W'(MAX_CHANNELS))
	else $error("channel counter out of range");

	// Neighbour indices are ordered and inside the source image when reads start
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD0 |-> (r0_q <= r1_q && c0_q <= c1_q
		                       && r1_q <= src_last && c1_q <= src_last))
	else $error("neighbour indices out of order or past the edge");

	// A new result appears only at the end of an emit
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == ST_MIX3)
	else $error("result raised outside the final blend state");

	// The frame store is never read and written in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.we && mem_req.re))
	else $error("frame store read and write collide");

endmodule

`default_nettype wire

/* design/bir_store.sv */
`default_nettype none

module bir_store (
	input  wire logic                          clk,
	input  wire bir_pkg::bir_mem_req_t         req,
	output logic [bir_pkg::SAMPLE_W-1:0]       rdata
);
	import bir_pkg::*;

	logic [SAMPLE_W-1:0]      mem [0:STORE_DEPTH-1];
	logic [2*SRC_W-1:0]       lin;
	logic [ADDR_W-1:0]        addr;

	// Interleave channels: (row * MAX_SRC_SIZE + col) * MAX_CHANNELS + chan
	assign lin  = {req.row, req.col};
	assign addr = ADDR_W'(lin) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(req.chan);

	// Write one sample or read one with a registered result
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[addr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

/* tb/resizer_checker.sv */
`timescale 1ns / 1ps

module resizer_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_wen,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_wdata,

	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	// load_row[8:0], load_col[17:9], load_channel[19:18], sample[27:20], zero pad
	input  wire logic [31:0] s_axis_tdata,
	// func[0]
	input  wire logic [0:0]  s_axis_tuser,

	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// value[7:0], out_row[17:8], out_col[27:18], out_channel[29:28], zero pad
	input  wire logic [31:0] m_axis_tdata,
	input  wire logic        m_axis_tlast,

	output int               errors,
	output int               pending
);
	import bir_pkg::*;

	localparam longint unsigned WEIGHT_ONE = 64'd1 << FRAC_BITS;
	localparam longint unsigned HALF_LSB   = 64'd1 << (2 * FRAC_BITS - 1);

	typedef struct {
		int value;
		int row;
		int col;
		int chan;
		int last;
	} pixel_t;

	pixel_t           expected_pixels [$];
	bit [7:0]         frame_mem [STORE_DEPTH];

	// register shadow, masked to the register widths
	int src_reg;
	int dst_reg;
	int chan_reg;
	int step_reg;

	// output position counters
	int row_cnt;
	int col_cnt;
	int chan_cnt;

	function automatic int clamp_to(input int v, input int lo, input int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic int sample_addr(input int r, input int c, input int ch);
		return (r * MAX_SRC_SIZE + c) * MAX_CHANNELS + ch;
	endfunction

	// Split count*step into clamped floor and ceil source indices and the fraction.
	function automatic void locate_axis(input int count, input int last_idx, output int lo,
			output int hi, output longint unsigned frac);
		longint unsigned pos;
		longint unsigned whole;
		pos = longint'(count) * longint'(step_reg);
		whole = pos >> FRAC_BITS;
		frac = pos & (WEIGHT_ONE - 1);
		lo = (whole > last_idx) ? last_idx : int'(whole);
		if (frac != 0)
			whole++;
		hi = (whole > last_idx) ? last_idx : int'(whole);
	endfunction

	// Interpolate the sample at the current counters, then advance them.
	function automatic pixel_t next_pixel();
		int src_n;
		int dst_n;
		int nch_n;
		int rd;
		int r0;
		int r1;
		int c0;
		int c1;
		longint unsigned fr;
		longint unsigned fc;
		longint unsigned upper;
		longint unsigned lower;
		longint unsigned sum;
		longint unsigned val;
		pixel_t px;
		src_n = clamp_to(src_reg, 1, MAX_SRC_SIZE);
		dst_n = clamp_to(dst_reg, 1, MAX_DST_SIZE);
		nch_n = clamp_to(chan_reg, 1, MAX_CHANNELS);
		rd = (chan_cnt < MAX_CHANNELS) ? chan_cnt : MAX_CHANNELS - 1;
		locate_axis(row_cnt, src_n - 1, r0, r1, fr);
		locate_axis(col_cnt, src_n - 1, c0, c1, fc);
		upper = (WEIGHT_ONE - fc) * frame_mem[sample_addr(r0, c0, rd)]
			+ fc * frame_mem[sample_addr(r0, c1, rd)];
		lower = (WEIGHT_ONE - fc) * frame_mem[sample_addr(r1, c0, rd)]
			+ fc * frame_mem[sample_addr(r1, c1, rd)];
		sum = (WEIGHT_ONE - fr) * upper + fr * lower;
		val = (sum + HALF_LSB) >> (2 * FRAC_BITS);
		if (val > 255)
			val = 255;
		px.value = int'(val);
		px.row = row_cnt & 10'h3FF;
		px.col = col_cnt & 10'h3FF;
		px.chan = chan_cnt & 2'h3;
		px.last = 0;
		// advance channel, then column, then row; the row wrap ends the frame
		chan_cnt = chan_cnt + 1;
		if (chan_cnt >= nch_n) begin
			chan_cnt = 0;
			col_cnt = col_cnt + 1;
			if (col_cnt >= dst_n) begin
				col_cnt = 0;
				row_cnt = row_cnt + 1;
				if (row_cnt >= dst_n) begin
					row_cnt = 0;
					px.last = 1;
				end
			end
		end
		return px;
	endfunction

	function automatic void check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			errors++;
		end
	endfunction

	// Track register writes, model loads and emits, and compare every result.
	always @(posedge clk or negedge arst_n) begin : watch
		pixel_t want;
		if (!arst_n) begin
			src_reg = 512;
			dst_reg = 650;
			chan_reg = 3;
			step_reg = 51601;
			row_cnt = 0;
			col_cnt = 0;
			chan_cnt = 0;
			errors = 0;
			expected_pixels.delete();
			pending <= 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					CFG_SRC_SIZE:   src_reg = cfg_wdata & 24'h3FF;
					CFG_DST_SIZE:   dst_reg = cfg_wdata & 24'h7FF;
					CFG_CHANNELS:   chan_reg = cfg_wdata & 24'h3;
					CFG_STEP_RATIO: step_reg = cfg_wdata;
					default: ;
				endcase
			end

			// compare an accepted result with the oldest expectation
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t ns: output %h tlast %b arrived with nothing expected",
						$time, m_axis_tdata, m_axis_tlast);
					errors++;
				end else begin
					want = expected_pixels.pop_front();
					check_field("value", want.value, m_axis_tdata[7:0]);
					check_field("out_row", want.row, m_axis_tdata[17:8]);
					check_field("out_col", want.col, m_axis_tdata[27:18]);
					check_field("out_channel", want.chan, m_axis_tdata[29:28]);
					check_field("last_of_frame", want.last, m_axis_tlast);
				end
			end

			// store a load, drop one aimed at a missing channel, predict an emit
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser[0] == FUNC_LOAD) begin
					if (s_axis_tdata[19:18] < MAX_CHANNELS)
						frame_mem[sample_addr(s_axis_tdata[8:0], s_axis_tdata[17:9],
							s_axis_tdata[19:18])] = s_axis_tdata[27:20];
				end else begin
					expected_pixels.push_back(next_pixel());
				end
			end
			pending <= expected_pixels.size();
		end
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
	import bir_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int ITEM_TARGET = 1750;
	localparam int SETTLE      = 16;

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        cfg_wen = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [23:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	wire         s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	wire         m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire [31:0]  m_axis_tdata;
	wire         m_axis_tlast;

	int errors;
	int pending;

	// geometry as the block sees it, after saturation
	int src_px;
	int dst_px;
	int nch;
	int step_q;
	// where the next emit lands, used to load its neighbors first
	int row_at;
	int col_at;
	int chan_at;
	bit loaded [STORE_DEPTH];

	int items_sent = 0;
	bit quiet_sender = 1'b0;
	int ready_hold = 0;
	int cycles = 0;

	bilinear_image_resizer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	resizer_checker pixel_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.errors        (errors),
		.pending       (pending)
	);

	always #5 clk = ~clk;

	// Stop a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Stall the result side: long ready stretches, short and occasional long stalls.
	always @(posedge clk or negedge arst_n) begin : ready_gen
		int roll;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			ready_hold <= 0;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 50) begin
				m_axis_tready <= 1'b1;
				ready_hold <= $urandom_range(0, 30);
			end else if (roll < 88) begin
				m_axis_tready <= 1'b0;
				ready_hold <= $urandom_range(0, 2);
			end else begin
				m_axis_tready <= 1'b0;
				ready_hold <= $urandom_range(10, 40);
			end
		end
	end

	function automatic int clamp_to(input int v, input int lo, input int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic int store_index(input int r, input int c, input int ch);
		return (r * MAX_SRC_SIZE + c) * MAX_CHANNELS + ch;
	endfunction

	// Source rows or columns that an output counter reads.
	function automatic void source_span(input int count, output int lo, output int hi);
		longint unsigned pos;
		longint unsigned whole;
		pos = longint'(count) * longint'(step_q);
		whole = pos >> FRAC_BITS;
		lo = (whole > src_px - 1) ? src_px - 1 : int'(whole);
		if (pos[FRAC_BITS-1:0] != 0)
			whole++;
		hi = (whole > src_px - 1) ? src_px - 1 : int'(whole);
	endfunction

	// Hold one request until it is taken, after an optional random gap.
	task automatic send_req(input logic kind, input int row, input int col, input int ch,
			input int smp);
		int roll;
		int gap;
		gap = 0;
		if (!quiet_sender) begin
			roll = $urandom_range(0, 99);
			if (roll >= 92)
				gap = $urandom_range(8, 30);
			else if (roll >= 60)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {4'd0, 8'(smp), 2'(ch), 9'(col), 9'(row)};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
		if (kind == FUNC_LOAD && ch < MAX_CHANNELS)
			loaded[store_index(row, col, ch)] = 1'b1;
	endtask

	// Load any neighbor not yet written, then request the next output sample.
	task automatic emit_next();
		int r [2];
		int c [2];
		source_span(row_at, r[0], r[1]);
		source_span(col_at, c[0], c[1]);
		for (int i = 0; i < 2; i++)
			for (int j = 0; j < 2; j++)
				if (!loaded[store_index(r[i], c[j], chan_at)])
					send_req(FUNC_LOAD, r[i], c[j], chan_at, $urandom_range(0, 255));
		send_req(FUNC_EMIT, $urandom_range(0, 511), $urandom_range(0, 511),
			$urandom_range(0, 3), $urandom_range(0, 255));
		chan_at++;
		if (chan_at >= nch) begin
			chan_at = 0;
			col_at++;
			if (col_at >= dst_px) begin
				col_at = 0;
				row_at++;
				if (row_at >= dst_px)
					row_at = 0;
			end
		end
	endtask

	// Lower valid and wait until every result is in and the block is quiet.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input bir_cfg_t idx, input int val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= 24'(val);
		@(posedge clk);
	endtask

	task automatic set_config(input int src, input int dst, input int chs, input int step);
		write_reg(CFG_SRC_SIZE, src);
		write_reg(CFG_DST_SIZE, dst);
		write_reg(CFG_CHANNELS, chs);
		write_reg(CFG_STEP_RATIO, step);
		cfg_wen <= 1'b0;
		@(posedge clk);
		src_px = clamp_to(src & 'h3FF, 1, MAX_SRC_SIZE);
		dst_px = clamp_to(dst & 'h7FF, 1, MAX_DST_SIZE);
		nch = clamp_to(chs & 'h3, 1, MAX_CHANNELS);
		step_q = step & 'hFFFFFF;
	endtask

	// Pick a geometry, then run a batch of mostly emits with loads mixed in.
	task automatic random_phase();
		int pick;
		int src;
		int dst;
		int chs;
		int step;
		int s1;
		int d1;
		int n;
		pick = $urandom_range(0, 99);
		src = $urandom_range(2, 12);
		dst = $urandom_range(2, 10);
		chs = $urandom_range(1, 3);
		if (pick < 10) begin
			src = 512;
			dst = $urandom_range(0, 1) ? 1024 : $urandom_range(2, 8);
		end else if (pick < 20) begin
			src = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(513, 1023);
			dst = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(1025, 2047);
			chs = $urandom_range(0, 3);
		end
		s1 = clamp_to(src, 1, MAX_SRC_SIZE) - 1;
		d1 = clamp_to(dst, 1, MAX_DST_SIZE) - 1;
		if (d1 == 0 || (pick >= 20 && pick < 32))
			step = $urandom_range(0, 24'hFFFFFF);
		else
			step = clamp_to((s1 << FRAC_BITS) / d1, 0, 24'hFFFFFF);
		set_config(src, dst, chs, step);
		quiet_sender = ($urandom_range(0, 3) == 0);
		n = $urandom_range(20, 80);
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 72)
				emit_next();
			else if (pick < 94)
				send_req(FUNC_LOAD, $urandom_range(0, src_px - 1), $urandom_range(0, src_px - 1),
					$urandom_range(0, 2), $urandom_range(0, 255));
			else
				send_req(FUNC_LOAD, $urandom_range(0, 511), $urandom_range(0, 511),
					$urandom_range(0, 3), $urandom_range(0, 255));
			if ($urandom_range(0, 149) == 0)
				drain();
		end
		drain();
	endtask

	initial begin
		src_px = 512;
		dst_px = 650;
		nch = 3;
		step_q = 51601;
		row_at = 0;
		col_at = 0;
		chan_at = 0;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners of the store, a dropped channel, then emits at reset geometry
		send_req(FUNC_LOAD, 511, 511, 2, 255);
		send_req(FUNC_LOAD, 0, 0, 0, 0);
		send_req(FUNC_LOAD, 0, 0, 3, 'hA5);
		send_req(FUNC_LOAD, 0, 1, 0, 255);
		repeat (4) emit_next();
		drain();

		// a step that puts every nonzero counter past the edge, frame wraps with tlast
		set_config(2, 2, 1, 24'hFFFFFF);
		repeat (4) emit_next();
		drain();

		// registers below range saturate to a one-sample frame
		set_config(0, 0, 0, 0);
		repeat (2) emit_next();
		drain();

		// counters left beyond a frame that shrinks under them
		set_config(4, 6, 3, (3 << FRAC_BITS) / 5);
		repeat (5) emit_next();
		drain();
		set_config(4, 2, 1, 3 << FRAC_BITS);
		repeat (2) emit_next();
		drain();

		while (items_sent < ITEM_TARGET)
			random_phase();

		drain();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
